FILE: sv/olst_pkg.sv
// ---------------------------------------------------------------------------
// olst_pkg: shared types and constants of the ordered list store
// Sizes, command and status codes, and the broadcast bundle sent to the cells.
// ---------------------------------------------------------------------------
package olst_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int VAL_W    = 32;
	localparam int POS_W    = 7;
	localparam int FIDX_W   = 6;
	localparam int LEN_W    = 7;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_INSERT_AT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_POP_FRONT  = 3'd4,
		CMD_REMOVE_AT  = 3'd5,
		CMD_GET_AT     = 3'd6,
		CMD_FIND       = 3'd7
	} olst_cmd_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_RANGE   = 2'd1,
		STS_FULL    = 2'd2,
		STS_MISSING = 2'd3
	} olst_status_t;

	typedef enum logic {
		S_IDLE    = 1'b0,
		S_COLLECT = 1'b1
	} olst_state_t;

	// control broadcast from the controller to every cell
	typedef struct packed {
		logic             fire;
		logic             shift_up;
		logic             shift_down;
		logic [IDX_W-1:0] at;
		logic [VAL_W-1:0] key;
		logic [CNT_W-1:0] count;
	} olst_bcast_t;

endpackage

FILE: sv/olst_cmd_if.sv
// ---------------------------------------------------------------------------
// olst_cmd_if: command channel
// valid/ready channel carrying one list command per transaction.
// ---------------------------------------------------------------------------
interface olst_cmd_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               command;
	logic signed [31:0]       item_value;
	logic [6:0]               position;

	modport source (output valid, command, item_value, position, input ready);
	modport sink   (input valid, command, item_value, position, output ready);
endinterface

FILE: sv/olst_res_if.sv
// ---------------------------------------------------------------------------
// olst_res_if: result channel
// valid/ready channel carrying one result per command.
// ---------------------------------------------------------------------------
interface olst_res_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [31:0]       result_value;
	logic [5:0]               found_index;
	logic [6:0]               length;

	modport source (output valid, status, result_value, found_index, length, input ready);
	modport sink   (input valid, status, result_value, found_index, length, output ready);
endinterface

FILE: sv/olst_cell.sv
// ---------------------------------------------------------------------------
// olst_cell: one list slot
// Holds one entry, shifts to or from its neighbors, and registers its own
// read-out and compare result for the controller.
// ---------------------------------------------------------------------------
module olst_cell (
	input  logic                       clk,
	input  olst_pkg::olst_bcast_t      bc,
	input  logic [olst_pkg::IDX_W-1:0] idx,
	input  logic [olst_pkg::VAL_W-1:0] left_data,
	input  logic [olst_pkg::VAL_W-1:0] right_data,
	output logic [olst_pkg::VAL_W-1:0] data,
	output logic [olst_pkg::VAL_W-1:0] pick_s1,
	output logic                       match_s1
);
	import olst_pkg::*;

	logic [VAL_W-1:0] data_q;
	logic             live;

	assign live = CNT_W'(idx) < bc.count;
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (bc.fire) begin
			pick_s1  <= (idx == bc.at) ? data_q : '0;
			match_s1 <= live && (data_q == bc.key);
			if (bc.shift_up) begin
				if (idx == bc.at) begin
					data_q <= bc.key;
				end else if (idx > bc.at) begin
					data_q <= left_data;
				end
			end else if (bc.shift_down && (idx >= bc.at)) begin
				data_q <= right_data;
			end
		end
	end

endmodule

FILE: sv/olst_ctrl.sv
// ---------------------------------------------------------------------------
// olst_ctrl: command decode, length counter and result register
// Checks each command against the length, drives the cell broadcast and
// gathers the registered cell outputs into one result.
// ---------------------------------------------------------------------------
module olst_ctrl (
	input  logic                                      clk,
	input  logic                                      arst_n,
	olst_cmd_if.sink                                  cmd,
	olst_res_if.source                                res,
	output olst_pkg::olst_bcast_t                     bc,
	input  logic [olst_pkg::CAPACITY-1:0][olst_pkg::VAL_W-1:0] pick,
	input  logic [olst_pkg::CAPACITY-1:0]             match
);
	import olst_pkg::*;

	olst_state_t      state_q, state_nxt;
	logic [CNT_W-1:0] count_q;
	olst_cmd_t        op;
	logic             fire, load, out_free;

	logic [CMP_W-1:0] cnt_x, pos_x, at_w;
	olst_status_t     sts_w;
	logic             up_w, down_w, rd_w;

	logic             find_s1, rd_s1;
	olst_status_t     sts_s1;

	logic [VAL_W-1:0] pick_or;
	logic [IDX_W-1:0] hit_idx;
	logic             any_hit;

	logic             res_valid_q;
	olst_status_t     res_sts_q;
	logic [VAL_W-1:0] res_val_q;
	logic [FIDX_W-1:0] res_fidx_q;
	logic [LEN_W-1:0] res_len_q;

	assign op       = olst_cmd_t'(cmd.command);
	assign fire     = cmd.valid && cmd.ready;
	assign out_free = !res_valid_q || res.ready;
	assign cnt_x    = CMP_W'(count_q);
	assign pos_x    = CMP_W'(cmd.position);

	// decode against the current length
	always_comb begin
		at_w   = '0;
		sts_w  = STS_OK;
		up_w   = 1'b0;
		down_w = 1'b0;
		rd_w   = 1'b0;
		unique case (op)
			CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT_AT: begin
				at_w = (op == CMD_PUSH_BACK) ? cnt_x :
				       (op == CMD_PUSH_FRONT) ? '0 : pos_x;
				if (cnt_x >= CMP_W'(CAPACITY)) begin
					sts_w = STS_FULL;
				end else if (at_w > cnt_x) begin
					sts_w = STS_RANGE;
				end else begin
					up_w = 1'b1;
				end
			end
			CMD_POP_BACK, CMD_POP_FRONT, CMD_REMOVE_AT: begin
				at_w = (op == CMD_POP_BACK) ? cnt_x - CMP_W'(1) :
				       (op == CMD_POP_FRONT) ? '0 : pos_x;
				if ((cnt_x == '0) || (at_w >= cnt_x)) begin
					sts_w = STS_RANGE;
				end else begin
					down_w = 1'b1;
					rd_w   = 1'b1;
				end
			end
			CMD_GET_AT: begin
				at_w = pos_x;
				if (pos_x >= cnt_x) begin
					sts_w = STS_RANGE;
				end else begin
					rd_w = 1'b1;
				end
			end
			CMD_FIND: begin
				at_w = '0;
			end
			default: begin
				at_w = '0;
			end
		endcase
	end

	assign bc.fire       = fire;
	assign bc.shift_up   = fire && up_w;
	assign bc.shift_down = fire && down_w;
	assign bc.at         = at_w[IDX_W-1:0];
	assign bc.key        = VAL_W'(cmd.item_value);
	assign bc.count      = count_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:    if (fire) state_nxt = S_COLLECT;
			S_COLLECT: if (out_free) state_nxt = S_IDLE;
			default:   state_nxt = S_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		cmd.ready = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			S_IDLE:    cmd.ready = 1'b1;
			S_COLLECT: load = out_free;
			default:   cmd.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (fire && up_w) begin
				count_q <= count_q + CNT_W'(1);
			end else if (fire && down_w) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			find_s1 <= (op == CMD_FIND);
			rd_s1   <= rd_w;
			sts_s1  <= sts_w;
		end
	end

	// gather cell outputs: at most one pick is nonzero
	always_comb begin
		pick_or = '0;
		hit_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pick_or = pick_or | pick[i];
		end
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) hit_idx = IDX_W'(i);
		end
	end
	assign any_hit = |match;

	always_ff @(posedge clk) begin
		if (load) begin
			if (find_s1) begin
				res_sts_q  <= any_hit ? STS_OK : STS_MISSING;
				res_fidx_q <= any_hit ? FIDX_W'(hit_idx) : '0;
			end else begin
				res_sts_q  <= sts_s1;
				res_fidx_q <= '0;
			end
			res_val_q <= rd_s1 ? pick_or : '0;
			res_len_q <= LEN_W'(count_q);
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = res_sts_q;
	assign res.result_value = signed'(res_val_q);
	assign res.found_index  = res_fidx_q;
	assign res.length       = res_len_q;

endmodule

FILE: sv/ordered_list_store.sv
// ---------------------------------------------------------------------------
// ordered_list_store: bounded ordered list with insert, remove and search
// A row of cells holds the list; inserts and removes shift the row by one
// slot at the accepting edge, reads and finds are compared in every cell at once.
// ---------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  cmd     | in  | valid/ready  | command, item_value, position
//  res     | out | valid/ready  | status, result_value, found_index, length
//
//  The accepting edge of a command shifts the cells and registers each
//  cell's read-out and match bit; the collect state then reduces them into
//  the result register once it is free. cmd.ready is high only in idle.
//  A full result register holds the controller in its collect state.
//  Reset clears the length, the state machine and res.valid; the entries
//  are not cleared and are only read below the length.
// ---------------------------------------------------------------------------
module ordered_list_store (
	input  logic       clk,
	input  logic       arst_n,
	olst_cmd_if.sink   cmd,
	olst_res_if.source res
);
	import olst_pkg::*;

	olst_bcast_t                        bc;
	logic [CAPACITY-1:0][VAL_W-1:0]     data;
	logic [CAPACITY-1:0][VAL_W-1:0]     pick;
	logic [CAPACITY-1:0]                match;

	olst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res),
		.bc     (bc),
		.pick   (pick),
		.match  (match)
	);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		olst_cell u_cell (
			.clk        (clk),
			.bc         (bc),
			.idx        (IDX_W'(g)),
			.left_data  ((g == 0) ? data[g] : data[(g == 0) ? 0 : g - 1]),
			.right_data ((g == CAPACITY - 1) ? data[g] :
			             data[(g == CAPACITY - 1) ? g : g + 1]),
			.data       (data[g]),
			.pick_s1    (pick[g]),
			.match_s1   (match[g])
		);
	end

endmodule

FILE: sv/olst_chk.sv
// ---------------------------------------------------------------------------
// olst_chk: port-level checks of the ordered list store
// Watches both channels and the result fields over time.
// ---------------------------------------------------------------------------
module olst_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  status,
	input logic [31:0] result_value,
	input logic [5:0]  found_index,
	input logic [6:0]  length
);
	import olst_pkg::*;

	// a result waiting for its transaction stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before its transaction");

	// one command at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while one is in flight");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == STS_FULL) |-> (length == LEN_W'(CAPACITY)))
		else $error("full status with list not full");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status != STS_OK) |-> (result_value == '0) && (found_index == '0))
		else $error("error result carries data");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (length <= LEN_W'(CAPACITY)))
		else $error("length beyond capacity");

endmodule

bind ordered_list_store olst_chk u_olst_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.status       (res.status),
	.result_value (res.result_value),
	.found_index  (res.found_index),
	.length       (res.length)
);
